// ----- design/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types, codes and defaults for the scheduler and its slot memory.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int SLOTS_DEFAULT = 16;

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED   = 3'd0,
		ST_FULL       = 3'd1,
		ST_ZERO_BURST = 3'd2,
		ST_RAN        = 3'd3,
		ST_IDLE       = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_TURN,
		S_WAIT,
		S_SUM
	} state_t;

	typedef struct packed {
		op_t         operation;
		logic [7:0]  job_id;
		logic [7:0]  job_priority;
		logic [15:0] burst_length;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  running_id;
		logic        done_valid;
		logic [7:0]  done_id;
		logic [7:0]  done_priority;
		logic [31:0] done_arrival;
		logic [15:0] done_burst;
		logic [31:0] done_completion;
		logic [31:0] done_turnaround;
		logic [31:0] done_wait;
		logic [31:0] wait_total;
		logic [15:0] finished_count;
	} res_item_t;

	// One job slot as held in the slot memory.
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  priority_lvl;
		logic [31:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
	} slot_rec_t;

endpackage

// ----- design/pps_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/preemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Tick-driven scheduler over SLOTS job slots: arrivals fill the lowest free
// slot, ticks run the highest-priority job for one time unit.
// ----------------------------------------------------------------------------
//
//  channel   ports                       flow
//  --------  --------------------------  ------------------------------------
//  command   start, busy, request        item taken when start & !busy
//  result    result_strobe, result       one cycle per item, cannot be held
//
//  Sequence: an arrival with zero burst reports in the cycle after it is taken.
//  Any other arrival, and a tick that does not finish its job, runs through
//  SCAN, DRAIN and DECIDE; a tick that finishes its job adds TURN, WAIT, SUM.
//  The sweep over the slot memory reads one slot per cycle
//  through its single read port, sharing one priority comparator.
//  Reset: all slots free, time, wait sum and finish count at zero; the slot
//  memory itself is not cleared, a slot's data is used only while its valid bit is set.
//  Stalls: the receiver cannot stall; busy stays high until the result is
//  on its way, and the next item may be taken in the cycle the result shows.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
	parameter int SLOTS = pps_pkg::SLOTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pps_pkg::in_item_t request,
	output logic              result_strobe,
	output pps_pkg::res_item_t result
);

	localparam int IW = $clog2(SLOTS);
	localparam int RW = $bits(pps_pkg::slot_rec_t);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	pps_pkg::state_t    state_q, state_d;
	pps_pkg::in_item_t  cmd_q;
	logic [SLOTS-1:0]   valid_q;
	logic [IW-1:0]      cnt_q;

	// free-slot search
	logic               found_q;
	logic [IW-1:0]      free_q;

	// scan data stage
	logic               rd_vld_s1;
	logic [IW-1:0]      idx_s1;
	logic               slotv_s1;

	// best candidate so far
	logic               have_best_q;
	logic [IW-1:0]      best_idx_q;
	pps_pkg::slot_rec_t best_q;

	logic [31:0]        time_q;
	logic [31:0]        wsum_q;
	logic [15:0]        fin_q;
	logic [31:0]        turn_q;
	logic [31:0]        wait_q;

	// slot memory ports
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	pps_pkg::slot_rec_t ram_wrec;
	logic               ram_re;
	logic [RW-1:0]      ram_rdata;
	pps_pkg::slot_rec_t rd_rec;

	pps_pkg::res_item_t res_d;
	logic               strobe_d;
	logic [15:0]        rem_dec;

	assign rd_rec  = pps_pkg::slot_rec_t'(ram_rdata);
	assign rem_dec = best_q.remaining - 16'd1;
	assign busy    = (state_q != pps_pkg::S_IDLE);
	assign ram_re  = (state_q == pps_pkg::S_SCAN);

	pps_ram #(
		.WIDTH(RW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (RW'(ram_wrec)),
		.re    (ram_re),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	// Next state, memory writes and the result to launch.
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = free_q;
		ram_wrec  = '{id: cmd_q.job_id, priority_lvl: cmd_q.job_priority,
			arrival: time_q, burst: cmd_q.burst_length, remaining: cmd_q.burst_length};
		strobe_d  = 1'b0;
		res_d     = '0;
		res_d.wait_total     = wsum_q;
		res_d.finished_count = fin_q;

		case (state_q)
			pps_pkg::S_IDLE: begin
				if (start) begin
					// A zero burst is refused at once, before any slot search.
					if (request.operation == pps_pkg::OP_ARRIVE &&
						request.burst_length == 16'd0) begin
						strobe_d     = 1'b1;
						res_d.status = pps_pkg::ST_ZERO_BURST;
					end else begin
						state_d = pps_pkg::S_SCAN;
					end
				end
			end
			pps_pkg::S_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = pps_pkg::S_DRAIN;
				end
			end
			pps_pkg::S_DRAIN: begin
				state_d = pps_pkg::S_DECIDE;
			end
			pps_pkg::S_DECIDE: begin
				if (cmd_q.operation == pps_pkg::OP_ARRIVE) begin
					state_d  = pps_pkg::S_IDLE;
					strobe_d = 1'b1;
					if (found_q) begin
						ram_we       = 1'b1;
						res_d.status = pps_pkg::ST_ACCEPTED;
					end else begin
						res_d.status = pps_pkg::ST_FULL;
					end
				end else if (!have_best_q) begin
					state_d      = pps_pkg::S_IDLE;
					strobe_d     = 1'b1;
					res_d.status = pps_pkg::ST_IDLE;
				end else begin
					// Write back the decremented remaining time.
					ram_we             = 1'b1;
					ram_waddr          = best_idx_q;
					ram_wrec           = best_q;
					ram_wrec.remaining = rem_dec;
					if (rem_dec != 16'd0) begin
						state_d          = pps_pkg::S_IDLE;
						strobe_d         = 1'b1;
						res_d.status     = pps_pkg::ST_RAN;
						res_d.running_id = best_q.id;
					end else begin
						state_d = pps_pkg::S_TURN;
					end
				end
			end
			pps_pkg::S_TURN: begin
				state_d = pps_pkg::S_WAIT;
			end
			pps_pkg::S_WAIT: begin
				state_d = pps_pkg::S_SUM;
			end
			pps_pkg::S_SUM: begin
				state_d               = pps_pkg::S_IDLE;
				strobe_d              = 1'b1;
				res_d.status          = pps_pkg::ST_RAN;
				res_d.running_id      = best_q.id;
				res_d.done_valid      = 1'b1;
				res_d.done_id         = best_q.id;
				res_d.done_priority   = best_q.priority_lvl;
				res_d.done_arrival    = best_q.arrival;
				res_d.done_burst      = best_q.burst;
				res_d.done_completion = time_q;
				res_d.done_turnaround = turn_q;
				res_d.done_wait       = wait_q;
				res_d.wait_total      = wsum_q + wait_q;
				res_d.finished_count  = fin_q + 16'd1;
			end
			default: begin
				state_d = pps_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: slot occupancy, sweep position, totals and the strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			cnt_q         <= '0;
			found_q       <= 1'b0;
			rd_vld_s1     <= 1'b0;
			have_best_q   <= 1'b0;
			time_q        <= '0;
			wsum_q        <= '0;
			fin_q         <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= strobe_d;
			rd_vld_s1     <= (state_q == pps_pkg::S_SCAN);

			if (state_q == pps_pkg::S_IDLE) begin
				cnt_q       <= '0;
				found_q     <= 1'b0;
				have_best_q <= 1'b0;
			end

			if (state_q == pps_pkg::S_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
				// Take the lowest free slot; valid bits need no memory read.
				if (!valid_q[cnt_q] && !found_q) begin
					found_q <= 1'b1;
				end
			end

			// Data stage of the sweep: keep the first strictly higher priority.
			if (rd_vld_s1 && slotv_s1 &&
				(!have_best_q || rd_rec.priority_lvl > best_q.priority_lvl)) begin
				have_best_q <= 1'b1;
			end

			if (state_q == pps_pkg::S_DECIDE) begin
				if (cmd_q.operation == pps_pkg::OP_ARRIVE) begin
					if (found_q) begin
						valid_q[free_q] <= 1'b1;
					end
				end else begin
					time_q <= time_q + 32'd1;
					if (have_best_q && rem_dec == 16'd0) begin
						valid_q[best_idx_q] <= 1'b0;
					end
				end
			end

			if (state_q == pps_pkg::S_SUM) begin
				wsum_q <= wsum_q + wait_q;
				fin_q  <= fin_q + 16'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == pps_pkg::S_IDLE && start) begin
			cmd_q <= request;
		end
		if (state_q == pps_pkg::S_SCAN) begin
			idx_s1   <= cnt_q;
			slotv_s1 <= valid_q[cnt_q];
			if (!valid_q[cnt_q] && !found_q) begin
				free_q <= cnt_q;
			end
		end
		if (rd_vld_s1 && slotv_s1 &&
			(!have_best_q || rd_rec.priority_lvl > best_q.priority_lvl)) begin
			best_q     <= rd_rec;
			best_idx_q <= idx_s1;
		end
		// Time has already advanced here, so it is the completion time.
		if (state_q == pps_pkg::S_TURN) begin
			turn_q <= time_q - best_q.arrival;
		end
		if (state_q == pps_pkg::S_WAIT) begin
			wait_q <= turn_q - {16'd0, best_q.burst};
		end
		if (strobe_d) begin
			result <= res_d;
		end
	end

	// A finished job is only reported together with a run.
	a_done_is_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.done_valid |-> result.status == pps_pkg::ST_RAN)
		else $error("finish reported without a run");

	// An accepted arrival occupies exactly one more slot.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status == pps_pkg::ST_ACCEPTED |->
		$countones(valid_q) == $countones($past(valid_q)) + 1)
		else $error("accepted arrival did not take one slot");

	// A finish frees exactly one slot; the slot drops in DECIDE, before TURN, WAIT, SUM and the report.
	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.done_valid |->
		$countones(valid_q) + 1 == $countones($past(valid_q, 4)))
		else $error("finished job did not free one slot");

	// The finish counter on the result matches the internal count.
	a_finish_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> result.finished_count == fin_q)
		else $error("finished count out of step");

	// Memory read data is only consumed right after a sweep read.
	a_scan_stage: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == pps_pkg::S_SCAN || state_q == pps_pkg::S_DRAIN))
		else $error("read data stage outside the sweep");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Drives arrive and tick items through the command port in random bursts,
// tracks the slot table in a local scheduling model and checks every result
// item field by field against the model's prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int SLOTS        = pps_pkg::SLOTS_DEFAULT;
	localparam int RANDOM_ITEMS = 1550;
	// Wait twice the span of the longest item, a finishing tick, for stray results.
	localparam int DRAIN_CYCLES = 2 * (SLOTS + 6);

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	pps_pkg::in_item_t  request = '0;
	logic               busy;
	logic               result_strobe;
	pps_pkg::res_item_t result;

	pps_pkg::in_item_t  pending_items[$];
	pps_pkg::res_item_t expected_results[$];

	// Local copy of the slot table and the scheduler counters.
	logic        job_live[SLOTS];
	logic [7:0]  job_tag[SLOTS];
	logic [7:0]  job_prio[SLOTS];
	logic [31:0] job_arrival[SLOTS];
	logic [15:0] job_burst[SLOTS];
	logic [15:0] job_left[SLOTS];
	logic [31:0] model_time     = '0;
	logic [31:0] model_wait_sum = '0;
	logic [15:0] model_finished = '0;

	int mismatches = 0;
	int gap_left   = 0;
	int burst_left = 1;
	int n_stored   = 0;
	int n_full     = 0;
	int n_zero     = 0;
	int n_ran      = 0;
	int n_idle     = 0;
	int n_finished = 0;

	preemptive_priority_scheduler #(
		.SLOTS(SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_strobe(result_strobe),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one item to the local table and return the result item it causes.
	function automatic pps_pkg::res_item_t schedule_step(input pps_pkg::in_item_t it);
		pps_pkg::res_item_t r;
		int                 best;
		int                 free_slot;
		logic [31:0]        turn;
		logic [31:0]        waited;
		r = '0;
		best = -1;
		free_slot = -1;
		if (it.operation == pps_pkg::OP_ARRIVE) begin
			// Zero burst wins over full table: check it first.
			if (it.burst_length == 16'd0) begin
				r.status = pps_pkg::ST_ZERO_BURST;
				n_zero++;
			end else begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!job_live[i] && free_slot < 0) begin
						free_slot = i;
					end
				end
				if (free_slot < 0) begin
					r.status = pps_pkg::ST_FULL;
					n_full++;
				end else begin
					// Fill the lowest free slot, stamped with the present time.
					job_live[free_slot]    = 1'b1;
					job_tag[free_slot]     = it.job_id;
					job_prio[free_slot]    = it.job_priority;
					job_arrival[free_slot] = model_time;
					job_burst[free_slot]   = it.burst_length;
					job_left[free_slot]    = it.burst_length;
					r.status = pps_pkg::ST_ACCEPTED;
					n_stored++;
				end
			end
		end else begin
			// Strict greater-than keeps the lowest index on a priority tie.
			for (int i = 0; i < SLOTS; i++) begin
				if (job_live[i] && (best < 0 || job_prio[i] > job_prio[best])) begin
					best = i;
				end
			end
			// Advance time on every tick, idle or not.
			model_time = model_time + 32'd1;
			if (best < 0) begin
				r.status = pps_pkg::ST_IDLE;
				n_idle++;
			end else begin
				r.status     = pps_pkg::ST_RAN;
				r.running_id = job_tag[best];
				n_ran++;
				job_left[best] = job_left[best] - 16'd1;
				if (job_left[best] == 16'd0) begin
					turn   = model_time - job_arrival[best];
					waited = turn - {16'd0, job_burst[best]};
					model_wait_sum = model_wait_sum + waited;
					model_finished = model_finished + 16'd1;
					job_live[best] = 1'b0;
					r.done_valid      = 1'b1;
					r.done_id         = job_tag[best];
					r.done_priority   = job_prio[best];
					r.done_arrival    = job_arrival[best];
					r.done_burst      = job_burst[best];
					r.done_completion = model_time;
					r.done_turnaround = turn;
					r.done_wait       = waited;
					n_finished++;
				end
			end
		end
		r.wait_total     = model_wait_sum;
		r.finished_count = model_finished;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic add_arrive(input logic [7:0] id, input logic [7:0] prio,
			input logic [15:0] burst);
		pps_pkg::in_item_t it;
		it.operation    = pps_pkg::OP_ARRIVE;
		it.job_id       = id;
		it.job_priority = prio;
		it.burst_length = burst;
		pending_items.insert(pending_items.size(), it);
	endtask

	// Fill the ignored fields of a tick with junk so they get exercised too.
	task automatic add_tick();
		pps_pkg::in_item_t it;
		it.operation    = pps_pkg::OP_TICK;
		it.job_id       = 8'($urandom_range(0, 255));
		it.job_priority = 8'($urandom_range(0, 255));
		it.burst_length = 16'($urandom_range(0, 16'hFFFF));
		pending_items.insert(pending_items.size(), it);
	endtask

	// Driver: hold the item while busy, else open a gap or issue the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			start   <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), schedule_step(request));
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					// Count the gap only once the block is free again.
					if (!busy) begin
						gap_left--;
					end
				end else if (pending_items.size() > 0) begin
					start   <= 1'b1;
					request <= pending_items.pop_front();
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: take every strobed result and compare with the oldest prediction.
	always @(posedge clk) begin
		pps_pkg::res_item_t want;
		if (arst_n && result_strobe) begin
			if (expected_results.size() == 0) begin
				$error("result item with no prediction pending");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("running_id", 32'(want.running_id), 32'(result.running_id));
				check_field("done_valid", 32'(want.done_valid), 32'(result.done_valid));
				check_field("done_id", 32'(want.done_id), 32'(result.done_id));
				check_field("done_priority", 32'(want.done_priority),
					32'(result.done_priority));
				check_field("done_arrival",    want.done_arrival,    result.done_arrival);
				check_field("done_burst", 32'(want.done_burst), 32'(result.done_burst));
				check_field("done_completion", want.done_completion, result.done_completion);
				check_field("done_turnaround", want.done_turnaround, result.done_turnaround);
				check_field("done_wait",       want.done_wait,       result.done_wait);
				check_field("wait_total",      want.wait_total,      result.wait_total);
				check_field("finished_count", 32'(want.finished_count),
					32'(result.finished_count));
			end
		end
	end

	initial begin : stimulus
		int directed_count;
		int pick;
		int n;
		int b;
		int owed;
		int ticked;
		int extra;
		logic [7:0] prio;

		for (int i = 0; i < SLOTS; i++) begin
			job_live[i] = 1'b0;
		end

		// Directed: idle tick, zero burst, the smallest job at the field minimums.
		add_tick();
		add_arrive(8'hFF, 8'hFF, 16'h0000);
		add_arrive(8'h00, 8'h00, 16'h0001);
		add_tick();
		// Priority tie between two slots, then preemption by a late urgent job.
		add_arrive(8'h11, 8'h05, 16'h0003);
		add_arrive(8'h22, 8'h05, 16'h0002);
		add_tick();
		add_arrive(8'h33, 8'hC8, 16'h0001);
		repeat (6) add_tick();
		// Fill the table, then overflow with an all-ones burst and send a zero burst.
		for (int i = 0; i < SLOTS; i++) begin
			add_arrive(8'(i * 16 + 15 - i), (i[0] ? 8'hAA : 8'h55), 16'h0001);
		end
		add_arrive(8'hFF, 8'hFF, 16'hFFFF);
		add_arrive(8'h00, 8'h00, 16'h0000);
		directed_count = pending_items.size();

		// Random: mostly arrival groups followed by enough ticks to drain them.
		while (pending_items.size() < directed_count + RANDOM_ITEMS) begin
			pick   = $urandom_range(0, 19);
			owed   = 0;
			ticked = 0;
			if (pick == 0) begin
				if ($urandom_range(0, 1) == 1) begin
					add_tick();
				end else begin
					add_arrive(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						16'($urandom_range(0, 15)));
				end
			end else if (pick == 1) begin
				// Overrun the table: anything past SLOTS in a row must be turned away.
				n = $urandom_range(SLOTS + 1, SLOTS + 4);
				for (int k = 0; k < n; k++) begin
					if (k < SLOTS) begin
						b = $urandom_range(1, 4);
						owed += b;
						add_arrive(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							16'(b));
					end else begin
						add_arrive(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 16'hFFFF)));
					end
				end
			end else begin
				n = $urandom_range(1, 5);
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						b = 0;
					end else if ($urandom_range(0, 7) == 0) begin
						b = $urandom_range(7, 48);
					end else begin
						b = $urandom_range(1, 6);
					end
					// Narrow priorities half the time to force ties.
					prio = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3))
						: 8'($urandom_range(0, 255));
					add_arrive(8'($urandom_range(0, 255)), prio, 16'(b));
					owed += b;
					extra = $urandom_range(0, 2);
					repeat (extra) add_tick();
					ticked += extra;
				end
			end
			extra = $urandom_range(0, 3);
			while (ticked < owed + extra) begin
				add_tick();
				ticked++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d predicted result items never arrived", expected_results.size());
			mismatches++;
		end
		$display("Ran %0d items: %0d jobs stored, %0d turned away full, %0d zero burst",
			n_stored + n_full + n_zero + n_ran + n_idle, n_stored, n_full, n_zero);
		$display("Ticks: %0d ran a job, %0d idle; %0d jobs finished, %0d mismatches",
			n_ran, n_idle, n_finished, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#6000000;
		$display("FAIL");
		$finish;
	end

endmodule
